// ----- design/dsks_pkg.sv -----
package dsks_pkg;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_CENTRE_X    = 2'd0,
		REG_CENTRE_Y    = 2'd1,
		REG_DWELL_LIMIT = 2'd2
	} cfg_reg_t;

	localparam int unsigned COUNT_WIDTH = 6;
	localparam int unsigned SECTOR_WIDTH = 3;
	localparam int unsigned MENU_WIDTH = 3;
	localparam int unsigned CHAR_WIDTH = 7;
	localparam int unsigned KEY_INDEX_WIDTH = 6;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = 6'd63;
	localparam logic [COUNT_WIDTH-1:0] DWELL_LIMIT_RESET = 6'd13;

	// Sector codes, counted counter-clockwise from the right.
	localparam logic [SECTOR_WIDTH-1:0] SECTOR_RIGHT      = 3'd0;
	localparam logic [SECTOR_WIDTH-1:0] SECTOR_UP_RIGHT   = 3'd1;
	localparam logic [SECTOR_WIDTH-1:0] SECTOR_UP_LEFT    = 3'd2;
	localparam logic [SECTOR_WIDTH-1:0] SECTOR_LEFT       = 3'd3;
	localparam logic [SECTOR_WIDTH-1:0] SECTOR_DOWN_LEFT  = 3'd4;
	localparam logic [SECTOR_WIDTH-1:0] SECTOR_DOWN_RIGHT = 3'd5;

	localparam logic [MENU_WIDTH-1:0] MENU_TOP = 3'd0;
	localparam logic [MENU_WIDTH-1:0] MENU_FIRST_SUB = 3'd1;
	localparam logic [MENU_WIDTH-1:0] MENU_LAST_SUB = 3'd6;

	localparam logic [CHAR_WIDTH-1:0] CHAR_NONE = 7'd0;

	// Key table, one row of six keys per submenu, indexed by row * 6 + sector.
	localparam logic [CHAR_WIDTH-1:0] KEY_ROM [36] = '{
		7'h48, 7'h47, 7'h4C, 7'h4B, 7'h4A, 7'h49,
		7'h42, 7'h41, 7'h46, 7'h45, 7'h44, 7'h43,
		7'h36, 7'h35, 7'h20, 7'h39, 7'h38, 7'h37,
		7'h30, 7'h5A, 7'h34, 7'h33, 7'h32, 7'h31,
		7'h55, 7'h54, 7'h59, 7'h58, 7'h57, 7'h56,
		7'h4E, 7'h4D, 7'h53, 7'h52, 7'h50, 7'h4F
	};

endpackage

// ----- design/dwell_sector_key_selector_unit.sv -----
// Dwell sector key selector. Each input transaction carries one pointer
// position per video frame; the block measures its offset from the dial
// centre (x mirrored, y pointing up), sorts it into one of six 60-degree
// sectors by exact integer comparison of 3*dy*dy against dx*dx, and counts
// how many frames in a row land in the same sector. When that count exceeds
// dwell_limit the counter clears: on the top menu the block opens submenu
// sector+1, and inside a submenu it emits the key character of the 6x6 key
// table and returns to the top menu. Every input transaction produces exactly
// one output transaction. The block accepts one transaction per clock cycle
// while its results are taken, through one input register stage, then the
// squaring, sector decision and dwell update, which are all combinational,
// then the result register. The input stage moves into the result
// register whenever that register is empty or its transaction is taken in the
// same cycle. A waiting result lets one more transaction into the input stage;
// after that, in_ready stays low until the result is taken. Configuration
// writes take effect at once and must only be issued while no transaction is
// in flight.
module dwell_sector_key_selector_unit #(
	parameter int unsigned COORD_WIDTH = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [COORD_WIDTH-1:0]        cfg_data,
	// input channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [COORD_WIDTH-1:0]        point_x,
	input  logic [COORD_WIDTH-1:0]        point_y,
	// output channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [dsks_pkg::SECTOR_WIDTH-1:0] sector,
	output logic [dsks_pkg::MENU_WIDTH-1:0]   menu_level,
	output logic                          key_valid,
	output logic [dsks_pkg::CHAR_WIDTH-1:0]   key_char
);
	import dsks_pkg::*;

	localparam int unsigned SQ_WIDTH = 2 * COORD_WIDTH;

	// Configuration registers.
	logic [COORD_WIDTH-1:0] centre_x_q;
	logic [COORD_WIDTH-1:0] centre_y_q;
	logic [COUNT_WIDTH-1:0] dwell_limit_q;

	// Input stage.
	logic                   valid_s1;
	logic [COORD_WIDTH-1:0] point_x_s1;
	logic [COORD_WIDTH-1:0] point_y_s1;

	// Dwell state.
	logic [SECTOR_WIDTH-1:0] last_sector_q;
	logic [COUNT_WIDTH-1:0]  dwell_count_q;
	logic [MENU_WIDTH-1:0]   current_menu_q;

	// Result register.
	logic                    out_valid_q;
	logic [SECTOR_WIDTH-1:0] sector_q;
	logic [MENU_WIDTH-1:0]   menu_level_q;
	logic                    key_valid_q;
	logic [CHAR_WIDTH-1:0]   key_char_q;

	// Combinational datapath.
	logic                    advance;
	logic [COORD_WIDTH:0]    dx;
	logic [COORD_WIDTH:0]    dy;
	logic [COORD_WIDTH:0]    dx_neg;
	logic [COORD_WIDTH:0]    dy_neg;
	logic [COORD_WIDTH-1:0]  dx_abs;
	logic [COORD_WIDTH-1:0]  dy_abs;
	logic [SQ_WIDTH-1:0]     dx_sq;
	logic [SQ_WIDTH-1:0]     dy_sq;
	logic [SQ_WIDTH+1:0]     dy_sq3;
	logic                    near_axis;
	logic                    dx_zero;
	logic                    dx_neg_flag;
	logic                    dy_neg_flag;
	logic [SECTOR_WIDTH-1:0] sec;
	logic [COUNT_WIDTH-1:0]  count_next;
	logic                    fire;
	logic [COUNT_WIDTH-1:0]  count_new;
	logic [MENU_WIDTH-1:0]   menu_new;
	logic                    kvalid_new;
	logic [CHAR_WIDTH-1:0]   kchar_new;
	logic [MENU_WIDTH-1:0]   menu_row;
	logic [KEY_INDEX_WIDTH-1:0] key_index;

	// The input stage moves into the result register when the result register
	// is empty or its transaction is being taken in this cycle.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_x_q    <= COORD_WIDTH'(320);
			centre_y_q    <= COORD_WIDTH'(240);
			dwell_limit_q <= DWELL_LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CENTRE_X:    centre_x_q <= cfg_data;
				REG_CENTRE_Y:    centre_y_q <= cfg_data;
				REG_DWELL_LIMIT: dwell_limit_q <= cfg_data[COUNT_WIDTH-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			point_x_s1 <= point_x;
			point_y_s1 <= point_y;
		end
	end

	// Offsets with x mirrored and y pointing up; one extra bit holds the sign.
	assign dx     = {1'b0, centre_x_q} - {1'b0, point_x_s1};
	assign dy     = {1'b0, centre_y_q} - {1'b0, point_y_s1};
	assign dx_neg = -dx;
	assign dy_neg = -dy;
	assign dx_neg_flag = dx[COORD_WIDTH];
	assign dy_neg_flag = dy[COORD_WIDTH];
	assign dx_abs = dx_neg_flag ? dx_neg[COORD_WIDTH-1:0] : dx[COORD_WIDTH-1:0];
	assign dy_abs = dy_neg_flag ? dy_neg[COORD_WIDTH-1:0] : dy[COORD_WIDTH-1:0];
	assign dx_zero = (dx == '0);

	assign dx_sq  = SQ_WIDTH'(dx_abs) * SQ_WIDTH'(dx_abs);
	assign dy_sq  = SQ_WIDTH'(dy_abs) * SQ_WIDTH'(dy_abs);
	assign dy_sq3 = {1'b0, dy_sq, 1'b0} + {2'b00, dy_sq};
	// The offset lies within 30 degrees of the x axis.
	assign near_axis = dy_sq3 < {2'b00, dx_sq};

	// Sector decision from the quadrant and the near-axis test. The centre
	// point itself is caught first and counts as the right-hand sector.
	always_comb begin
		if (dx_zero && (dy == '0)) begin
			sec = SECTOR_RIGHT;
		end else if (!dy_neg_flag) begin
			if (dx_zero) begin
				sec = SECTOR_UP_LEFT;
			end else if (!dx_neg_flag) begin
				sec = near_axis ? SECTOR_RIGHT : SECTOR_UP_RIGHT;
			end else begin
				sec = near_axis ? SECTOR_LEFT : SECTOR_UP_LEFT;
			end
		end else if (dx_neg_flag) begin
			sec = near_axis ? SECTOR_LEFT : SECTOR_DOWN_LEFT;
		end else begin
			sec = near_axis ? SECTOR_RIGHT : SECTOR_DOWN_RIGHT;
		end
	end

	// Dwell counter and menu update.
	always_comb begin
		if (sec != last_sector_q) begin
			count_next = '0;
		end else if (dwell_count_q < COUNT_MAX) begin
			count_next = dwell_count_q + 1'b1;
		end else begin
			count_next = dwell_count_q;
		end
		fire = count_next > dwell_limit_q;

		menu_row  = current_menu_q - MENU_FIRST_SUB;
		key_index = {1'b0, menu_row, 2'b00} + {2'b00, menu_row, 1'b0} + {3'b000, sec};

		count_new  = count_next;
		menu_new   = current_menu_q;
		kvalid_new = 1'b0;
		kchar_new  = CHAR_NONE;
		if (fire) begin
			count_new = '0;
			if (current_menu_q == MENU_TOP) begin
				menu_new = sec + MENU_FIRST_SUB;
			end else begin
				if (current_menu_q inside {[MENU_FIRST_SUB:MENU_LAST_SUB]}) begin
					kvalid_new = 1'b1;
					kchar_new  = KEY_ROM[key_index];
				end
				menu_new = MENU_TOP;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sector_q  <= SECTOR_RIGHT;
			dwell_count_q  <= '0;
			current_menu_q <= MENU_TOP;
		end else if (advance) begin
			last_sector_q  <= sec;
			dwell_count_q  <= count_new;
			current_menu_q <= menu_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sector_q     <= sec;
			menu_level_q <= menu_new;
			key_valid_q  <= kvalid_new;
			key_char_q   <= kchar_new;
		end
	end

	assign out_valid  = out_valid_q;
	assign sector     = sector_q;
	assign menu_level = menu_level_q;
	assign key_valid  = key_valid_q;
	assign key_char   = key_char_q;

endmodule
